@@ rtl/eiphp_pkg.sv @@
// ---------------------------------------------------------------------------
// eiphp_pkg
// shared types and constants for the ethernet ip header parser
// ---------------------------------------------------------------------------
package eiphp_pkg;

    typedef enum logic [5:0] {
        PH_ETH       = 6'b000001,
        PH_PPPOE     = 6'b000010,
        PH_IP        = 6'b000100,
        PH_TRANSPORT = 6'b001000,
        PH_L2TP      = 6'b010000,
        PH_DONE      = 6'b100000
    } t_phase;

    localparam logic [15:0] TYPE_VLAN  = 16'h8100;
    localparam logic [15:0] TYPE_PPPOE = 16'h8864;
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] PPP_IPV4   = 16'h0021;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [15:0] L2TP_RESET = 16'd1701;
    localparam logic [17:0] MIN_AFTER_IP  = 18'd28;
    localparam logic [17:0] MIN_TRANSPORT = 18'd4;
    localparam logic [17:0] MIN_TCP       = 18'd16;
    localparam logic [17:0] MIN_L2TP      = 18'd50;
    localparam logic [5:0]  UDP_HDR       = 6'd8;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] tcp_seq;
        logic [31:0] tcp_ack;
        logic [7:0]  tcp_flags;
        logic [15:0] tcp_window;
        logic [11:0] payload_offset;
        logic [11:0] payload_length;
    } t_result;

endpackage

@@ rtl/eiphp_cfg.sv @@
// ---------------------------------------------------------------------------
// eiphp_cfg
// apb register holding the l2tp port
// ---------------------------------------------------------------------------
module eiphp_cfg import eiphp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_l2tp_port
);
    logic [15:0] r_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port <= L2TP_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_port <= pwdata[15:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = (paddr == 2'd0) ? {16'd0, r_port} : 32'd0;
    assign o_l2tp_port = r_port;
endmodule

@@ rtl/eiphp_core.sv @@
// ---------------------------------------------------------------------------
// eiphp_core
// per-byte header parse state and frame-end result
// ---------------------------------------------------------------------------
module eiphp_core import eiphp_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 2048,
    parameter int MAX_VLAN_TAGS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_l2tp_port,
    output t_result     o_res
);
    localparam int OW = $clog2(MAX_FRAME_BYTES + 1);

    logic [OW-1:0] r_off, n_off;
    t_phase        r_ph, n_ph;
    logic [3:0]    r_tags, n_tags;
    logic [OW+1:0] r_ls, n_ls;
    logic [17:0]   r_need, n_need;
    logic          r_rej, n_rej;
    logic [7:0]    r_prev;
    logic [15:0]   r_tot, n_tot;
    logic [5:0]    r_ihb, n_ihb;
    logic [5:0]    r_thb, n_thb;
    logic [63:0]   r_f0, n_f0, r_f1, n_f1, r_f2, n_f2, r_f3, n_f3;

    logic [OW+1:0] rel, pos1;
    logic [15:0]   word;
    logic [17:0]   plen;
    logic          ok;

    function automatic logic [17:0] mx(input logic [17:0] a, input logic [17:0] b);
        mx = (b > a) ? b : a;
    endfunction

    always_comb begin
        n_off = r_off; n_ph = r_ph; n_tags = r_tags; n_ls = r_ls; n_need = r_need;
        n_rej = r_rej; n_tot = r_tot; n_ihb = r_ihb; n_thb = r_thb;
        n_f0 = r_f0; n_f1 = r_f1; n_f2 = r_f2; n_f3 = r_f3;
        rel  = (OW+2)'(r_off) - r_ls;
        pos1 = (OW+2)'(r_off) + 1'b1;
        word = {r_prev, i_byte};
        if (32'(r_off) >= MAX_FRAME_BYTES) begin
            n_rej = 1'b1;
        end else begin
            n_off = r_off + 1'b1;
            if (!r_rej) begin
                unique case (r_ph)
                    PH_ETH: begin
                        if (rel == 13) begin
                            if (word == TYPE_VLAN && 32'(r_tags) < MAX_VLAN_TAGS) begin
                                n_tags = r_tags + 1'b1;
                                n_ls   = r_ls + 3'd4;
                            end else if (word == TYPE_PPPOE
                                         && 32'(r_tags) < MAX_VLAN_TAGS) begin
                                n_ph = PH_PPPOE;
                            end else if (word == TYPE_IPV4) begin
                                n_ph   = PH_IP;
                                n_ls   = pos1;
                                n_need = mx(r_need, 18'(pos1) + MIN_AFTER_IP);
                            end else begin
                                n_rej = 1'b1;
                            end
                        end
                    end
                    PH_PPPOE: begin
                        if (rel == 21) begin
                            if (word == PPP_IPV4) begin
                                n_ph   = PH_IP;
                                n_ls   = pos1;
                                n_need = mx(r_need, 18'(pos1) + MIN_AFTER_IP);
                            end else begin
                                n_rej = 1'b1;
                            end
                        end
                    end
                    PH_IP: begin
                        if (rel == 0) begin
                            n_ihb = {i_byte[3:0], 2'b00};
                            if (i_byte[7:4] != 4'h4 || i_byte[3:0] < 4'd5)
                                n_rej = 1'b1;
                        end else if (rel == 3) begin
                            n_tot  = word;
                            n_need = mx(r_need, 18'(r_ls) + 18'(word));
                        end else if (rel == 9) begin
                            if (i_byte != PROTO_TCP && i_byte != PROTO_UDP)
                                n_rej = 1'b1;
                            n_f1 = {24'd0, i_byte, 32'd0};
                        end else if (rel >= 12 && rel <= 19) begin
                            n_f0 = {r_f0[55:0], i_byte};
                        end
                        if (!n_rej && rel >= 19 && rel == (OW+2)'(r_ihb) - 1'b1) begin
                            n_ph   = PH_TRANSPORT;
                            n_ls   = pos1;
                            n_need = mx(n_need, 18'(pos1) + MIN_TRANSPORT);
                            n_f2   = '0;
                            n_f3   = '0;
                        end
                    end
                    PH_TRANSPORT: begin
                        if (rel < 4) n_f1 = {r_f1[63:32], r_f1[23:0], i_byte};
                        if (rel == 3) begin
                            if (r_f1[39:32] == PROTO_UDP) begin
                                if (r_f1[23:8] == i_l2tp_port
                                    && {r_f1[7:0], i_byte} == i_l2tp_port) begin
                                    n_ph   = PH_L2TP;
                                    n_need = mx(r_need, 18'(r_ls) + MIN_L2TP);
                                end else begin
                                    n_thb = UDP_HDR;
                                    n_ph  = PH_DONE;
                                end
                            end else begin
                                n_need = mx(r_need, 18'(r_ls) + MIN_TCP);
                            end
                        end else if (rel >= 4 && rel <= 11) begin
                            n_f2 = {r_f2[55:0], i_byte};
                        end else if (rel == 12) begin
                            n_thb  = {i_byte[7:4], 2'b00};
                            n_need = mx(r_need, 18'(r_ls) + 18'({i_byte[7:4], 2'b00}));
                        end else if (rel >= 13 && rel <= 15) begin
                            n_f3 = {40'd0, r_f3[15:0], i_byte};
                            if (rel == 15) n_ph = PH_DONE;
                        end
                    end
                    PH_L2TP: begin
                        if (rel == 17) begin
                            if (word == PPP_IPV4) begin
                                n_ph = PH_IP;
                                n_ls = pos1;
                            end else begin
                                n_rej = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        plen = 18'(n_tot) - 18'(n_ihb) - 18'(n_thb);
        ok = !n_rej && n_ph == PH_DONE && 18'(n_off) >= n_need && !plen[17];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_off <= '0; r_ph <= PH_ETH; r_tags <= '0; r_ls <= '0; r_need <= '0;
            r_rej <= 1'b0; r_prev <= '0; r_tot <= '0; r_ihb <= '0; r_thb <= '0;
            r_f0 <= '0; r_f1 <= '0; r_f2 <= '0; r_f3 <= '0;
        end else if (i_en) begin
            r_off <= n_off; r_ph <= n_ph; r_tags <= n_tags; r_ls <= n_ls;
            r_need <= n_need; r_rej <= n_rej; r_prev <= i_byte; r_tot <= n_tot;
            r_ihb <= n_ihb; r_thb <= n_thb;
            r_f0 <= n_f0; r_f1 <= n_f1; r_f2 <= n_f2; r_f3 <= n_f3;
        end
    end

    always_comb begin
        o_res = '0;
        if (ok) begin
            o_res.accepted       = 1'b1;
            o_res.protocol       = n_f1[39:32];
            o_res.src_ip         = n_f0[63:32];
            o_res.dst_ip         = n_f0[31:0];
            o_res.src_port       = n_f1[31:16];
            o_res.dst_port       = n_f1[15:0];
            o_res.tcp_seq        = n_f2[63:32];
            o_res.tcp_ack        = n_f2[31:0];
            o_res.tcp_flags      = n_f3[23:16];
            o_res.tcp_window     = n_f3[15:0];
            o_res.payload_offset = 12'(n_ls + (OW+2)'(n_thb));
            o_res.payload_length = plen[11:0];
        end
    end

    a_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_tags) <= MAX_VLAN_TAGS) else $error("tag count overflow");
    a_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_off) <= MAX_FRAME_BYTES) else $error("offset overflow");
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_last) |=> (r_off == '0 && r_ph == PH_ETH))
        else $error("frame state not cleared");
endmodule

@@ rtl/ethernet_ip_header_parser_unit.sv @@
// ---------------------------------------------------------------------------
// ethernet_ip_header_parser_unit
// byte stream ethernet/vlan/pppoe/ipv4/tcp/udp header parser
// ---------------------------------------------------------------------------
// the output register captures the result when the last byte of a frame is accepted
// throughput: one byte per cycle unless the input is stalled, set by the single-pass parse logic
// output register holds the result; input is stalled only while it is held
// synchronous active-low reset clears the parse state, l2tp port to 1701
module ethernet_ip_header_parser_unit import eiphp_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 2048,
    parameter int MAX_VLAN_TAGS   = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // accepted, protocol, src_ip, dst_ip, src_port, dst_port, tcp_seq,
    // tcp_ack, tcp_flags, tcp_window, payload_offset, payload_length, pad
    output logic [223:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [15:0] l2tp_port;
    t_result     res;
    t_result     r_res;
    logic        r_vld;
    logic        en;

    assign s_axis_tready = !r_vld || m_axis_tready;
    assign en = s_axis_tvalid && s_axis_tready;

    eiphp_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_l2tp_port(l2tp_port)
    );

    eiphp_core #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES), .MAX_VLAN_TAGS(MAX_VLAN_TAGS)) u_core (
        .i_clk, .i_rst_n, .i_en(en), .i_byte(s_axis_tdata), .i_last(s_axis_tlast),
        .i_l2tp_port(l2tp_port), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en && s_axis_tlast) begin
            r_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && s_axis_tlast) r_res <= res;
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata = {7'd0, r_res.payload_length, r_res.payload_offset,
        r_res.tcp_window, r_res.tcp_flags, r_res.tcp_ack, r_res.tcp_seq,
        r_res.dst_port, r_res.src_port, r_res.dst_ip, r_res.src_ip,
        r_res.protocol, r_res.accepted};
endmodule
